// File: sv/imuca_pkg.sv
// Shared widths, defaults and arithmetic helpers for the IMU attitude estimator.
package imuca_pkg;

    localparam int CAL_SAMPLES_DEF = 256;
    localparam int CORDIC_ITER_DEF = 16;

    localparam int DW  = 17;  // offset-corrected axis
    localparam int QW  = 32;  // divider dividend / quotient
    localparam int DVW = 24;  // divider divisor
    localparam int CW  = 35;  // CORDIC x/y datapath
    localparam int ZW  = 33;  // CORDIC angle, 2^-24 degree

    // atan(2^-i) in 2^-24 degree
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 33'sd754974720;
            5'd1:    v = 33'sd445687602;
            5'd2:    v = 33'sd235489088;
            5'd3:    v = 33'sd119537938;
            5'd4:    v = 33'sd60000934;
            5'd5:    v = 33'sd30029717;
            5'd6:    v = 33'sd15018523;
            5'd7:    v = 33'sd7509720;
            5'd8:    v = 33'sd3754917;
            5'd9:    v = 33'sd1877466;
            5'd10:   v = 33'sd938734;
            5'd11:   v = 33'sd469367;
            5'd12:   v = 33'sd234684;
            5'd13:   v = 33'sd117342;
            5'd14:   v = 33'sd58671;
            5'd15:   v = 33'sd29335;
            5'd16:   v = 33'sd14668;
            5'd17:   v = 33'sd7334;
            5'd18:   v = 33'sd3667;
            5'd19:   v = 33'sd1833;
            5'd20:   v = 33'sd917;
            5'd21:   v = 33'sd458;
            5'd22:   v = 33'sd229;
            5'd23:   v = 33'sd115;
            5'd24:   v = 33'sd57;
            5'd25:   v = 33'sd29;
            5'd26:   v = 33'sd14;
            5'd27:   v = 33'sd7;
            5'd28:   v = 33'sd4;
            5'd29:   v = 33'sd2;
            5'd30:   v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -35'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: sv/imuca_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module imuca_div import imuca_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [QW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic [QW-1:0]  o_quot,
    output logic           o_done
);

    logic           r_busy;
    logic           r_done;
    logic [4:0]     r_cnt;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;
    logic [QW-1:0]  r_quo;
    logic [DVW:0]   w_trial;
    logic [DVW:0]   w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 5'd1;
            r_busy <= (r_cnt != 5'(QW - 1));
            r_done <= (r_cnt == 5'(QW - 1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVW-1:0] : w_trial[DVW-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

// File: sv/imuca_cordic.sv
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle.
module imuca_cordic import imuca_pkg::*; #(
    parameter int ITERS = CORDIC_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [CW-1:0] o_x,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_i;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i    <= r_i + 5'd1;
            r_busy <= (r_i != 5'(ITERS - 1));
            r_done <= (r_i == 5'(ITERS - 1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= '0;
        end else if (r_busy) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + atan_lut(r_i);
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - atan_lut(r_i);
            end
        end
    end

    assign o_x    = r_x;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

// File: sv/imu_complementary_attitude.sv
// Top level: calibration, rate scaling, accel tilt and complementary blend.
// The first CAL_SAMPLES words are only summed per axis and give no result; the
// last of them also starts six offset divisions through the bit-serial divider.
// A calibrated word then runs six divisions for rates and integration steps,
// six CORDIC vectoring passes at one micro-rotation per cycle, and two
// shift-add blend multiplies.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is accepted.
module imu_complementary_attitude import imuca_pkg::*; #(
    parameter int CAL_SAMPLES       = CAL_SAMPLES_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_roll_angle,
    output logic signed [31:0] o_pitch_angle,
    output logic signed [31:0] o_yaw_angle,
    output logic signed [18:0] o_roll_rate,
    output logic signed [18:0] o_pitch_rate,
    output logic signed [18:0] o_yaw_rate
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CALDIV = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_CORD   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_YAW    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [1:0] CFG_BLEND = 2'd0;
    localparam logic [1:0] CFG_GPD   = 2'd1;
    localparam logic [1:0] CFG_RATE  = 2'd2;
    localparam logic [1:0] CFG_GRAV  = 2'd3;

    // config
    logic [15:0] r_blend;
    logic [10:0] r_gpd;
    logic [12:0] r_srate;
    logic [14:0] r_grav;

    // control
    logic [2:0]  r_state;
    logic [2:0]  r_job;
    logic [3:0]  r_cnt;
    logic        r_go;
    logic        r_cal;
    logic [16:0] r_count;
    logic        r_ovalid;

    // state and working data
    logic signed [31:0]   r_sum [6];
    logic signed [31:0]   r_ang [3];
    logic signed [DW-1:0] r_d [6];
    logic signed [18:0]   r_rate [3];
    logic signed [24:0]   r_step [3];
    logic signed [17:0]   r_tilt [2];
    logic [DVW-1:0]       r_gsr;
    logic signed [CW-1:0] r_r;
    logic signed [CW-1:0] r_m;
    logic signed [49:0]   r_mop;
    logic signed [50:0]   r_macc;
    logic [15:0]          r_wsh;

    logic signed [15:0] w_v [6];
    logic               w_acc;
    logic [16:0]        n_count;
    logic [10:0]        w_gpd_eff;
    logic [12:0]        w_sr_eff;
    logic [1:0]         w_ph;
    logic               w_hi;

    // divider operands
    logic               w_div_start;
    logic               w_div_done;
    logic [QW-1:0]      w_div_q;
    logic               w_div_neg;
    logic [QW-1:0]      w_div_num;
    logic [DVW-1:0]     w_div_den;
    logic signed [DW-1:0] w_dsel;
    logic [15:0]        w_dmag;
    logic signed [33:0] w_qs;
    logic signed [18:0] w_rate_sat;

    // cordic operands
    logic                 w_cor_start;
    logic                 w_cor_done;
    logic signed [CW-1:0] w_cx0;
    logic signed [CW-1:0] w_cy0;
    logic signed [CW-1:0] w_cx;
    logic signed [ZW-1:0] w_cz;
    logic signed [17:0]   w_az;
    logic [17:0]          w_aaz;
    logic signed [DW-1:0] w_asel;
    logic signed [DW-1:0] w_nsel;
    logic [16:0]          w_nmag;
    logic signed [33:0]   w_zr;
    logic signed [17:0]   w_tilt;

    // blend operands
    logic signed [32:0]   w_t;
    logic signed [33:0]   w_diffm;
    logic signed [50:0]   w_macc_fin;

    assign w_v[0] = i_gyro_x;
    assign w_v[1] = i_gyro_y;
    assign w_v[2] = i_gyro_z;
    assign w_v[3] = i_accel_x;
    assign w_v[4] = i_accel_y;
    assign w_v[5] = i_accel_z;

    assign o_stall   = (r_state != ST_IDLE);
    assign w_acc     = i_valid && (r_state == ST_IDLE);
    assign n_count   = r_count + 17'd1;
    assign w_gpd_eff = (r_gpd == '0) ? 11'd1 : r_gpd;
    assign w_sr_eff  = (r_srate == '0) ? 13'd1 : r_srate;
    assign w_hi      = (r_job >= 3'd3);
    assign w_ph      = w_hi ? 2'(r_job - 3'd3) : r_job[1:0];

    // divider job select: offsets while calibrating, else rates then steps
    always_comb begin
        w_dsel = r_d[{1'b0, w_ph}];
        w_dmag = w_dsel[DW-1] ? 16'(-w_dsel) : w_dsel[15:0];
        if (r_state == ST_CALDIV) begin
            w_div_neg = r_sum[r_job][31];
            w_div_num = w_div_neg ? QW'(-r_sum[r_job]) : QW'(r_sum[r_job]);
            w_div_den = DVW'(CAL_SAMPLES);
        end else begin
            w_div_neg = w_dsel[DW-1];
            w_div_den = w_hi ? r_gsr : {13'd0, w_gpd_eff};
            // round half away from zero on the magnitude
            w_div_num = QW'({w_dmag, 8'd0}) + QW'(w_div_den >> 1);
        end
    end

    assign w_qs = w_div_neg ? -$signed({2'b00, w_div_q}) : $signed({2'b00, w_div_q});
    assign w_rate_sat = (w_qs > 34'sd262143)  ? 19'sd262143 :
                        (w_qs < -34'sd262144) ? -19'sd262144 : w_qs[18:0];

    assign w_div_start = r_go && (r_state inside {ST_DIV, ST_CALDIV});

    imuca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_quot     (w_div_q),
        .o_done     (w_div_done)
    );

    // cordic jobs per tilt: root, numerator gain, final angle
    always_comb begin
        w_az   = 18'(r_d[5]) + $signed({3'd0, r_grav});
        w_aaz  = w_az[17] ? 18'(-w_az) : 18'(w_az);
        w_asel = w_hi ? r_d[4] : r_d[3];
        w_nsel = w_hi ? r_d[3] : r_d[4];
        w_nmag = w_nsel[DW-1] ? 17'(-w_nsel) : 17'(w_nsel);
        case (w_ph)
            2'd0: begin
                w_cx0 = $signed(CW'({w_aaz, 12'd0}));
                w_cy0 = CW'(w_asel) <<< 12;
            end
            2'd1: begin
                w_cx0 = $signed(CW'({w_nmag, 12'd0}));
                w_cy0 = '0;
            end
            default: begin
                w_cx0 = r_r;
                w_cy0 = r_m;
            end
        endcase
        w_zr   = 34'(w_cz) + 34'sd32768;
        w_tilt = (r_r == '0 && r_m == '0) ? 18'sd0 : 18'(w_zr >>> 16);
    end

    assign w_cor_start = r_go && (r_state == ST_CORD);

    imuca_cordic #(
        .ITERS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (w_cx0),
        .i_y     (w_cy0),
        .o_x     (w_cx),
        .o_z     (w_cz),
        .o_done  (w_cor_done)
    );

    // w*t + (1-w)*tilt == tilt<<16 + w*(t - tilt)
    assign w_t     = 33'(r_ang[r_job[0]]) + 33'(r_step[r_job[0]]);
    assign w_diffm = 34'(w_t) - 34'(r_tilt[r_job[0]]);
    // accumulator including the partial product of the last weight bit
    assign w_macc_fin = r_wsh[0] ? r_macc + 51'(r_mop) : r_macc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= 16'd65470;
            r_gpd   <= 11'd65;
            r_srate <= 13'd200;
            r_grav  <= 15'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLEND: r_blend <= i_cfg_data;
                CFG_GPD:   r_gpd   <= i_cfg_data[10:0];
                CFG_RATE:  r_srate <= i_cfg_data[12:0];
                CFG_GRAV:  r_grav  <= i_cfg_data[14:0];
                default:   r_blend <= r_blend;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_job    <= '0;
            r_cnt    <= '0;
            r_go     <= 1'b0;
            r_cal    <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 6; k++) r_sum[k] <= '0;
            for (int k = 0; k < 3; k++) r_ang[k] <= '0;
        end else begin
            if (r_state == ST_OUT && (!r_ovalid || !i_stall))
                r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall)
                r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (!r_cal) begin
                            for (int k = 0; k < 6; k++)
                                r_sum[k] <= r_sum[k] + 32'(w_v[k]);
                            r_count <= n_count;
                            if (n_count >= 17'(CAL_SAMPLES)) begin
                                r_state <= ST_CALDIV;
                                r_job   <= '0;
                                r_go    <= 1'b1;
                            end
                        end else begin
                            r_state <= ST_DIV;
                            r_job   <= '0;
                            r_go    <= 1'b1;
                        end
                    end
                end
                ST_CALDIV: begin
                    r_go <= w_div_done && (r_job != 3'd5);
                    if (w_div_done) begin
                        r_sum[r_job] <= w_qs[31:0];
                        if (r_job == 3'd5) begin
                            r_cal   <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_job <= r_job + 3'd1;
                        end
                    end
                end
                ST_DIV: begin
                    r_go <= w_div_done;
                    if (w_div_done) begin
                        if (r_job == 3'd5) begin
                            r_state <= ST_CORD;
                            r_job   <= '0;
                        end else begin
                            r_job <= r_job + 3'd1;
                        end
                    end
                end
                ST_CORD: begin
                    r_go <= w_cor_done;
                    if (w_cor_done) begin
                        if (r_job == 3'd5) begin
                            r_state <= ST_MUL;
                            r_job   <= '0;
                        end else begin
                            r_job <= r_job + 3'd1;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_go) begin
                        r_go  <= 1'b0;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_ang[r_job[0]] <= sat32(35'(w_macc_fin >>> 16));
                            if (r_job[0]) begin
                                r_state <= ST_YAW;
                            end else begin
                                r_job <= 3'd1;
                                r_go  <= 1'b1;
                            end
                        end
                    end
                end
                ST_YAW: begin
                    r_ang[2] <= sat32(35'(r_ang[2]) + 35'(r_step[2]));
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc && r_cal) begin
            for (int k = 0; k < 6; k++)
                r_d[k] <= DW'(w_v[k]) - r_sum[k][DW-1:0];
            r_gsr <= DVW'(w_gpd_eff) * DVW'(w_sr_eff);
        end
        if (r_state == ST_DIV && w_div_done) begin
            if (w_hi)
                r_step[w_ph] <= w_qs[24:0];
            else
                r_rate[w_ph] <= w_rate_sat;
        end
        if (r_state == ST_CORD && w_cor_done) begin
            case (w_ph)
                2'd0:    r_r <= w_cx;
                2'd1:    r_m <= w_nsel[DW-1] ? -w_cx : w_cx;
                default: r_tilt[w_hi] <= w_hi ? -w_tilt : w_tilt;
            endcase
        end
        if (r_state == ST_MUL) begin
            if (r_go) begin
                r_mop  <= 50'(w_diffm);
                r_macc <= (51'(r_tilt[r_job[0]]) <<< 16) + 51'sd32768;
                r_wsh  <= r_blend;
            end else begin
                if (r_wsh[0])
                    r_macc <= r_macc + 51'(r_mop);
                r_mop <= r_mop <<< 1;
                r_wsh <= r_wsh >> 1;
            end
        end
        if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
            o_roll_angle  <= r_ang[0];
            o_pitch_angle <= r_ang[1];
            o_yaw_angle   <= r_ang[2];
            o_roll_rate   <= r_rate[0];
            o_pitch_rate  <= r_rate[1];
            o_yaw_rate    <= r_rate[2];
        end
    end

    assign o_valid = r_ovalid;

    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |=> r_cal)
        else $error("calibrated flag dropped");

    a_result_needs_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_cal)
        else $error("result before calibration finished");

    a_cal_word_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_cal) |=> (r_state == ST_IDLE || r_state == ST_CALDIV))
        else $error("calibration word started a run");

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_cor_start && r_job <= 3'd5)
        else $error("divider started out of sequence");

endmodule
